@@ src/pdpm_pkg.sv @@
package pdpm_pkg;

  // Storage sizes. The dictionary depth is a power of two, so addresses wrap
  // by truncation.
  localparam int DICT_BYTES = 128;
  localparam int DICT_AW    = $clog2(DICT_BYTES);
  localparam int MAX_TOKEN  = 32;
  localparam int TOK_IW     = $clog2(MAX_TOKEN);
  localparam int TLEN_W     = TOK_IW + 1;
  // A code index reaches the token length plus two.
  localparam int CODE_IW    = TLEN_W + 1;
  localparam int BITPOS_W   = CODE_IW + 3;

  // Request codes.
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_LOOKUP = 2'd2
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_MATCH = 2'd0,
    ST_FAIL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Which code of the current entry is being fetched.
  typedef enum logic [1:0] {
    KIND_LEN   = 2'd0,
    KIND_CLS   = 2'd1,
    KIND_CHAR  = 2'd2,
    KIND_EXACT = 2'd3
  } kind_e;

  // Source of the dictionary read address.
  typedef enum logic [1:0] {
    RD_HEAD   = 2'd0,
    RD_FIRST  = 2'd1,
    RD_SECOND = 2'd2
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;
    logic    walk_init;
    rd_sel_e rd_sel;
    kind_e   kind;
    logic    cap_hi;
    logic    use_code;
    logic    match;
    logic    next_word;
    logic    out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic tlen_zero;
    logic words_done;
    logic char_bad;
    logic char_last;
    logic past_end;
    logic found;
    logic out_free;
  } sts_t;

endpackage

@@ src/pdpm_ifs.sv @@
// Request channel: one word is a load, an append or a lookup.
interface pdpm_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] dict_addr;
  logic [7:0] dict_byte;
  logic [7:0] token_char;

  modport source (output valid, req_type, dict_addr, dict_byte, token_char, input ready);
  modport sink (input valid, req_type, dict_addr, dict_byte, token_char, output ready);
endinterface

// Response channel: one word per lookup.
interface pdpm_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] word_index;
  logic [7:0] word_class;
  logic       exact_match;

  modport source (output valid, status, word_index, word_class, exact_match, input ready);
  modport sink (input valid, status, word_index, word_class, exact_match, output ready);
endinterface

@@ src/pdpm_ram.sv @@
module pdpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ src/pdpm_ctrl.sv @@
module pdpm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [1:0]     req_type_i,
  input  pdpm_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output pdpm_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_COUNT, S_WORD, S_FA, S_FB, S_FD, S_MATCH, S_NEXT, S_FIN
  } state_e;

  state_e          state_q;
  pdpm_pkg::kind_e kind_q;

  assign in_ready_o = (state_q == S_IDLE);

  // Commands decoded from the current state.
  always_comb begin
    cmd_o           = '0;
    cmd_o.kind      = kind_q;
    cmd_o.rd_sel    = pdpm_pkg::RD_FIRST;
    cmd_o.take      = in_valid_i && (state_q == S_IDLE);
    cmd_o.walk_init = (state_q == S_COUNT);
    cmd_o.cap_hi    = (state_q == S_FB);
    cmd_o.use_code  = (state_q == S_FD);
    cmd_o.match     = (state_q == S_MATCH);
    cmd_o.next_word = (state_q == S_NEXT);
    cmd_o.out_load  = (state_q == S_FIN) && sts_i.out_free;
    if (state_q == S_HEAD) begin
      cmd_o.rd_sel = pdpm_pkg::RD_HEAD;
    end else if (state_q == S_FB) begin
      cmd_o.rd_sel = pdpm_pkg::RD_SECOND;
    end
  end

  // Sequencer for the dictionary walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= pdpm_pkg::KIND_LEN;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i && (req_type_i == pdpm_pkg::REQ_LOOKUP)) begin
            state_q <= sts_i.tlen_zero ? S_FIN : S_HEAD;
          end
        end
        S_HEAD:  state_q <= S_COUNT;
        S_COUNT: state_q <= S_WORD;
        S_WORD: begin
          if (sts_i.words_done) begin
            state_q <= S_FIN;
          end else begin
            kind_q  <= pdpm_pkg::KIND_LEN;
            state_q <= S_FA;
          end
        end
        S_FA: state_q <= S_FB;
        S_FB: state_q <= S_FD;
        S_FD: begin
          unique case (kind_q)
            pdpm_pkg::KIND_LEN: begin
              kind_q  <= pdpm_pkg::KIND_CHAR;
              state_q <= S_FA;
            end
            pdpm_pkg::KIND_CHAR: begin
              if (sts_i.char_bad) begin
                state_q <= S_NEXT;
              end else if (sts_i.char_last) begin
                kind_q  <= pdpm_pkg::KIND_CLS;
                state_q <= S_FA;
              end else begin
                state_q <= S_FA;
              end
            end
            pdpm_pkg::KIND_CLS: begin
              if (sts_i.past_end) begin
                state_q <= S_MATCH;
              end else begin
                kind_q  <= pdpm_pkg::KIND_EXACT;
                state_q <= S_FA;
              end
            end
            default: state_q <= S_MATCH;
          endcase
        end
        S_MATCH: state_q <= sts_i.found ? S_FIN : S_NEXT;
        S_NEXT:  state_q <= S_WORD;
        S_FIN: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ src/pdpm_dp.sv @@
module pdpm_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pdpm_pkg::cmd_t cmd_i,
  output pdpm_pkg::sts_t sts_o,
  input  logic           cfg_we_i,
  input  logic [4:0]     cfg_wdata_i,
  input  logic [1:0]     req_type_i,
  input  logic [6:0]     dict_addr_i,
  input  logic [7:0]     dict_byte_i,
  input  logic [7:0]     token_char_i,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  output logic [1:0]     status_o,
  output logic [7:0]     word_index_o,
  output logic [7:0]     word_class_o,
  output logic           exact_match_o
);

  localparam int AW = pdpm_pkg::DICT_AW;
  localparam int TW = pdpm_pkg::TLEN_W;
  localparam int KW = pdpm_pkg::CODE_IW;
  localparam int BW = pdpm_pkg::BITPOS_W;

  logic [4:0]    wec_q;
  logic [7:0]    tok_q [pdpm_pkg::MAX_TOKEN];
  logic [TW-1:0] tlen_q;
  logic [7:0]    nwords_q, w_q, idx_q;
  logic [AW-1:0] base_q;
  logic [4:0]    len_q, cand_cls_q, cls_q;
  logic [TW-1:0] j_q;
  logic [7:0]    hi_q;
  logic          cand_ex_q, ex_q, found_q, amb_q, out_valid_q;

  logic          we, append;
  logic [AW-1:0] raddr, addr_a;
  logic [7:0]    rdata;
  logic [KW-1:0] k;
  logic [BW-1:0] bitpos;
  logic [15:0]   pair;
  logic [3:0]    rsh;
  logic [4:0]    code;
  logic          code_end;
  logic [7:0]    adv_sum;
  logic [7:0]    len_p2;

  // Decode of an accepted request word.
  always_comb begin
    we     = 1'b0;
    append = 1'b0;
    if (cmd_i.take) begin
      case (req_type_i)
        pdpm_pkg::REQ_LOAD:   we = 1'b1;
        pdpm_pkg::REQ_APPEND: append = (token_char_i != 8'h00) && (token_char_i != 8'hff)
                                       && (tlen_q < TW'(pdpm_pkg::MAX_TOKEN));
        default: ;
      endcase
    end
  end

  // Code index of the current fetch and its bit position in the entry.
  always_comb begin
    case (cmd_i.kind)
      pdpm_pkg::KIND_LEN:  k = '0;
      pdpm_pkg::KIND_CLS:  k = KW'(1);
      pdpm_pkg::KIND_CHAR: k = KW'(j_q) + KW'(2);
      default:             k = KW'(tlen_q) + KW'(2);
    endcase
    bitpos = (BW'(k) << 2) + BW'(k);
    addr_a = base_q + AW'(bitpos[BW-1:3]);
    case (cmd_i.rd_sel)
      pdpm_pkg::RD_HEAD:   raddr = '0;
      pdpm_pkg::RD_SECOND: raddr = addr_a + AW'(1);
      default:             raddr = addr_a;
    endcase
  end

  pdpm_ram #(.WIDTH(8), .DEPTH(pdpm_pkg::DICT_BYTES)) u_dict (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(dict_addr_i)),
    .wdata_i (dict_byte_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Extract the 5-bit code from the two fetched bytes.
  always_comb begin
    pair     = {hi_q, rdata};
    rsh      = 4'd11 - {1'b0, bitpos[2:0]};
    code     = 5'(pair >> rsh);
    code_end = (code == 5'd0) || (code == wec_q);
    len_p2   = {3'b000, len_q} + 8'd2;
    adv_sum  = (len_p2 << 2) + len_p2 + 8'd7;
  end

  assign sts_o.tlen_zero  = (tlen_q == '0);
  assign sts_o.words_done = (w_q >= nwords_q);
  assign sts_o.char_bad   = (32'(j_q) >= 32'(len_q)) || code_end
                            || (tok_q[j_q[pdpm_pkg::TOK_IW-1:0]] != {3'b000, code});
  assign sts_o.char_last  = ((j_q + TW'(1)) == tlen_q);
  assign sts_o.past_end   = (32'(tlen_q) >= 32'(len_q));
  assign sts_o.found      = found_q;
  assign sts_o.out_free   = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;

  // Token store.
  always_ff @(posedge clk_i) begin
    if (append) begin
      tok_q[tlen_q[pdpm_pkg::TOK_IW-1:0]] <= token_char_i;
    end
  end

  // Walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_init) begin
      nwords_q <= rdata;
      w_q      <= '0;
      base_q   <= AW'(1);
    end
    if (cmd_i.cap_hi) begin
      hi_q <= rdata;
    end
    if (cmd_i.use_code) begin
      case (cmd_i.kind)
        pdpm_pkg::KIND_LEN: begin
          len_q <= code;
          j_q   <= '0;
        end
        pdpm_pkg::KIND_CHAR: j_q <= j_q + TW'(1);
        pdpm_pkg::KIND_CLS: begin
          cand_cls_q <= code;
          cand_ex_q  <= 1'b1;
        end
        default: cand_ex_q <= code_end;
      endcase
    end
    if (cmd_i.match && !found_q) begin
      idx_q <= w_q;
      cls_q <= cand_cls_q;
      ex_q  <= cand_ex_q;
    end
    if (cmd_i.next_word) begin
      w_q    <= w_q + 8'd1;
      base_q <= base_q + AW'(adv_sum[7:3]);
    end
    if (cmd_i.out_load) begin
      if (tlen_q == '0) begin
        status_o      <= pdpm_pkg::ST_EMPTY;
        word_index_o  <= 8'h00;
        word_class_o  <= 8'h00;
        exact_match_o <= 1'b0;
      end else if (!found_q || amb_q) begin
        status_o      <= pdpm_pkg::ST_FAIL;
        word_index_o  <= 8'hff;
        word_class_o  <= 8'hff;
        exact_match_o <= 1'b0;
      end else begin
        status_o      <= pdpm_pkg::ST_MATCH;
        word_index_o  <= idx_q;
        word_class_o  <= {3'b000, cls_q};
        exact_match_o <= ex_q;
      end
    end
  end

  // Control registers: end code, token length, match flags, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wec_q       <= 5'd31;
      tlen_q      <= '0;
      found_q     <= 1'b0;
      amb_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wec_q <= cfg_wdata_i;
      end
      if (append) begin
        tlen_q <= tlen_q + TW'(1);
      end else if (cmd_i.out_load) begin
        tlen_q <= '0;
      end
      if (cmd_i.walk_init) begin
        found_q <= 1'b0;
        amb_q   <= 1'b0;
      end else if (cmd_i.match) begin
        if (found_q) begin
          amb_q <= 1'b1;
        end
        found_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

@@ src/packed_dictionary_prefix_matcher_unit.sv @@
// Keyword lookup over a packed dictionary of 5-bit codes.
// Request channel (req_i): a load word writes one dictionary byte, an append
// word adds one character to the token unless it is 00 or ff or the token is
// full, and a lookup word compares the token as a prefix against the words,
// stops at a second match and then clears the token.
// Response channel (rsp_o): one word per lookup with status, word index,
// class and exact flag; loads and appends give no response.
// Configuration: cfg_we_i writes the word end code from cfg_wdata_i.
// Loads and appends are taken whenever the block is idle. A lookup first
// reads the word count and then walks the words; every 5-bit code needs two
// reads of the single dictionary read port and a decode step. A word is left
// at its first failing character; a matching word also fetches its class,
// and one more code when the exact test needs it. The response is valid in
// the cycle after it is loaded. The next request is taken once the lookup
// has placed its response in the output register. Reset clears the token
// and the output valid flag and sets the end code to 31; the dictionary and
// token contents are undefined until written. While the receiver stalls, the
// response holds in the output register; loads and appends are still taken
// until a further lookup is taken, and that lookup waits for the slot.
module packed_dictionary_prefix_matcher_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  pdpm_req_if.sink          req_i,
  pdpm_rsp_if.source        rsp_o,
  input  logic              cfg_we_i,
  input  logic [4:0]        cfg_wdata_i
);

  pdpm_pkg::cmd_t cmd;
  pdpm_pkg::sts_t sts;

  pdpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .req_type_i (req_i.req_type),
    .sts_i      (sts),
    .in_ready_o (req_i.ready),
    .cmd_o      (cmd)
  );

  pdpm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (req_i.req_type),
    .dict_addr_i   (req_i.dict_addr),
    .dict_byte_i   (req_i.dict_byte),
    .token_char_i  (req_i.token_char),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .status_o      (rsp_o.status),
    .word_index_o  (rsp_o.word_index),
    .word_class_o  (rsp_o.word_class),
    .exact_match_o (rsp_o.exact_match)
  );

`ifndef SYNTHESIS
  // A response is loaded only into a free output slot.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free) else $error("response loaded over a pending one");

  // A lookup always leaves an empty token behind.
  a_token_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> sts.tlen_zero) else $error("token not cleared after lookup");

  // No request is taken while a lookup finishes.
  a_no_take_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !req_i.ready) else $error("request taken during lookup");
`endif

endmodule

@@ sim/packed_dictionary_prefix_matcher_unit_tb.sv @@
module packed_dictionary_prefix_matcher_unit_tb;
  import pdpm_pkg::*;

  // Request code that the block ignores.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int MAX_WORDS = 8;
  localparam int MAX_WLEN  = 6;
  localparam int ITEMS_PER_PHASE = 285;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] addr;
    logic [7:0] data;
    logic [7:0] chr;
  } req_word_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] index;
    logic [7:0] cls;
    logic       exact;
  } lookup_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [4:0] cfg_wdata;

  pdpm_req_if req_bus ();
  pdpm_rsp_if rsp_bus ();

  packed_dictionary_prefix_matcher_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_bus.sink),
    .rsp_o       (rsp_bus.source),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow state of the block.
  logic [7:0] dict_mem [DICT_BYTES];
  logic [7:0] tok_mem [MAX_TOKEN];
  int unsigned tok_len;
  logic [4:0] end_code;

  // Lookup results still owed by the block.
  lookup_result_t lookup_q [$];

  int errors;
  int words_sent;
  int hold_request;

  // Dictionary being built by the stimulus, and the words in it.
  logic [7:0] dict_img [DICT_BYTES];
  int img_bytes;
  int n_words;
  int wlen [MAX_WORDS];
  int wchr [MAX_WORDS][MAX_WLEN];

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

  // 5-bit code number k of the entry that starts at byte base.
  function automatic logic [4:0] dict_code(int unsigned base, int unsigned k);
    int unsigned bp;
    logic [6:0] a;
    logic [6:0] b;
    logic [15:0] w;
    bp = 5 * k;
    a = 7'(base + bp / 8);
    b = a + 7'd1;
    w = {dict_mem[a], dict_mem[b]};
    return 5'(w >> (11 - bp % 8));
  endfunction

  // Character j of a word, or -1 past its end.
  function automatic int word_char(int unsigned base, int unsigned len, int unsigned j);
    logic [4:0] c;
    if (j >= len) return -1;
    c = dict_code(base, j + 2);
    if (c == 5'd0 || c == end_code) return -1;
    return int'(c);
  endfunction

  // Applies one accepted word to the shadow state; a lookup queues its result.
  function automatic void apply_request(req_word_t r);
    int unsigned base;
    int unsigned len;
    int unsigned hits;
    lookup_result_t res;
    bit ok;
    int c;
    case (r.kind)
      REQ_LOAD: dict_mem[r.addr] = r.data;
      REQ_APPEND: begin
        if (r.chr != 8'h00 && r.chr != 8'hff && tok_len < MAX_TOKEN) begin
          tok_mem[tok_len] = r.chr;
          tok_len++;
        end
      end
      REQ_LOOKUP: begin
        if (tok_len == 0) begin
          res = '{ST_EMPTY, 8'd0, 8'd0, 1'b0};
        end else begin
          base = 1;
          hits = 0;
          res = '{ST_FAIL, 8'hff, 8'hff, 1'b0};
          for (int w = 0; w < int'(dict_mem[0]) && hits < 2; w++) begin
            len = dict_code(base, 0);
            ok = 1'b1;
            for (int j = 0; j < int'(tok_len); j++) begin
              c = word_char(base, len, j);
              if (c < 0 || c != int'(tok_mem[j])) begin
                ok = 1'b0;
                break;
              end
            end
            if (ok) begin
              hits++;
              res.index = 8'(w);
              res.cls = 8'(dict_code(base, 1));
              res.exact = word_char(base, len, tok_len) < 0;
            end
            base = (base + (5 * (len + 2) + 7) / 8) % DICT_BYTES;
          end
          if (hits == 1) res.status = ST_MATCH;
          else res = '{ST_FAIL, 8'hff, 8'hff, 1'b0};
        end
        tok_len = 0;
        lookup_q.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one word and updates the shadow state once it is accepted.
  task automatic send_word(req_word_t r);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= r.kind;
    req_bus.dict_addr <= r.addr;
    req_bus.dict_byte <= r.data;
    req_bus.token_char <= r.chr;
    do @(posedge clk_i); while (!req_bus.ready);
    apply_request(r);
    words_sent++;
  endtask

  task automatic send_load(int a, int d);
    send_word('{REQ_LOAD, 7'(a), 8'(d), 8'($urandom)});
  endtask

  task automatic send_append(int c);
    send_word('{REQ_APPEND, 7'($urandom), 8'($urandom), 8'(c)});
  endtask

  task automatic send_lookup();
    send_word('{REQ_LOOKUP, 7'($urandom), 8'($urandom), 8'($urandom)});
  endtask

  // Drops valid and waits until every lookup result has come back.
  task automatic wait_idle();
    req_bus.valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_end_code(logic [4:0] code);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    end_code = code;
  endtask

  // Appends 5 bits at bit position pos of the image.
  task automatic pack_code(inout int pos, input logic [4:0] code);
    for (int i = 0; i < 5; i++) begin
      dict_img[pos / 8][7 - pos % 8] = code[4 - i];
      pos++;
    end
  endtask

  // Packs the word list into the image; the count goes into byte 0.
  task automatic pack_dictionary();
    int pos;
    for (int i = 0; i < DICT_BYTES; i++) dict_img[i] = 8'h00;
    dict_img[0] = 8'(n_words);
    pos = 8;
    for (int w = 0; w < n_words; w++) begin
      pack_code(pos, 5'(wlen[w]));
      pack_code(pos, 5'($urandom));
      for (int j = 0; j < wlen[w]; j++) pack_code(pos, 5'(wchr[w][j]));
      pos = (pos + 7) / 8 * 8;
    end
    img_bytes = pos / 8;
  endtask

  // A character code that does not end a word.
  function automatic int word_code(bit narrow);
    int c;
    do c = narrow ? $urandom_range(1, 4) : $urandom_range(1, 31);
    while (c == int'(end_code));
    return c;
  endfunction

  // Random word list, sometimes with an early end inside a word.
  task automatic random_dictionary();
    bit narrow;
    narrow = $urandom_range(0, 1);
    n_words = $urandom_range(0, MAX_WORDS);
    for (int w = 0; w < n_words; w++) begin
      wlen[w] = $urandom_range(0, MAX_WLEN);
      for (int j = 0; j < MAX_WLEN; j++) wchr[w][j] = word_code(narrow);
      if ($urandom_range(0, 9) == 0 && wlen[w] > 0)
        wchr[w][$urandom_range(0, wlen[w] - 1)] = $urandom_range(0, 1) ? end_code : 0;
    end
    pack_dictionary();
    for (int i = 0; i < img_bytes; i++) send_load(i, dict_img[i]);
  endtask

  // Token built from a prefix of a dictionary word, sometimes one too long
  // or with one character changed.
  task automatic prefix_lookup();
    int w;
    int n;
    int bad;
    if (n_words == 0) begin
      send_append($urandom_range(1, 31));
      send_lookup();
    end else begin
      w = $urandom_range(0, n_words - 1);
      n = $urandom_range(1, wlen[w] + 1);
      bad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int j = 0; j < n; j++) begin
        if (j == bad) send_append($urandom_range(1, 254));
        else if (j < wlen[w]) send_append(wchr[w][j]);
        else send_append($urandom_range(1, 31));
      end
      send_lookup();
    end
  endtask

  // A few words of any kind with random fields.
  task automatic noise_words();
    int k;
    int a;
    k = $urandom_range(1, 6);
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 3))
        0: begin
          a = $urandom_range(0, DICT_BYTES - 1);
          // A large count at byte 0 makes the walk long, so keep it rare.
          if (a == 0 && $urandom_range(0, 49) != 0) send_load(0, $urandom_range(0, 20));
          else send_load(a, $urandom);
        end
        1: send_append($urandom_range(0, 255));
        2: send_lookup();
        default: send_word('{REQ_UNUSED, 7'($urandom), 8'($urandom), 8'($urandom)});
      endcase
    end
  endtask

  // Fills the whole dictionary memory with a fixed word list.
  task automatic test_dictionary_load();
    int fixed_chr [6][MAX_WLEN];
    int fixed_len [6];
    fixed_len = '{2, 3, 4, 0, 3, 6};
    fixed_chr = '{'{7, 15, 0, 0, 0, 0}, '{7, 15, 1, 0, 0, 0},
                  '{20, 21, 22, 23, 0, 0}, '{0, 0, 0, 0, 0, 0},
                  '{5, 31, 6, 0, 0, 0}, '{1, 2, 3, 4, 5, 6}};
    n_words = 6;
    for (int w = 0; w < 6; w++) begin
      wlen[w] = fixed_len[w];
      for (int j = 0; j < MAX_WLEN; j++) wchr[w][j] = fixed_chr[w][j];
    end
    pack_dictionary();
    for (int i = 0; i < DICT_BYTES; i++) send_load(i, dict_img[i]);
  endtask

  // Empty token, unique prefix, exact match, ambiguous, no match, token longer
  // than the word, early word end, ignored characters, overfull token.
  task automatic test_directed_lookups();
    send_lookup();
    send_append(20);
    send_lookup();
    for (int j = 0; j < 4; j++) send_append(wchr[2][j]);
    send_lookup();
    send_append(7);
    send_lookup();
    send_append(20); send_append(21); send_append(22); send_append(23); send_append(24);
    send_lookup();
    send_append(5);
    send_append(0);
    send_append(255);
    send_lookup();
    send_append(40);
    send_append(254);
    send_lookup();
    send_word('{REQ_UNUSED, 7'h7f, 8'hff, 8'hff});
    for (int i = 0; i < MAX_TOKEN + 3; i++) send_append(1 + i % 6);
    send_lookup();
  endtask

  // The receiver holds off while lookups keep coming, so the input stalls.
  task automatic test_back_pressure();
    wait_idle();
    hold_request = 400;
    for (int i = 0; i < 6; i++) begin
      send_append(20);
      send_lookup();
    end
    wait_idle();
  endtask

  // Mostly well-formed dictionaries and tokens, with noise between them.
  task automatic test_random_traffic(logic [4:0] code, int count);
    int stop_at;
    int r;
    write_end_code(code);
    random_dictionary();
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 12) random_dictionary();
      else if (r < 82) prefix_lookup();
      else noise_words();
    end
  endtask

  // Receiver: random stalls, plus one long hold-off when asked for.
  initial begin : rsp_ready_driver
    int stall;
    int hold_left;
    bit hold_done;
    stall = 0;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0 && !hold_done) begin
        hold_left = hold_request;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp_bus.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 20) begin
        stall = rand_gap();
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Compares each result word with the oldest expected lookup result.
  always @(posedge clk_i) begin : result_checker
    lookup_result_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (lookup_q.size() == 0) begin
        $display("%0t: unexpected result word status=%0d index=%0d", $time,
                 rsp_bus.status, rsp_bus.word_index);
        errors++;
      end else begin
        want = lookup_q.pop_front();
        if (rsp_bus.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   rsp_bus.status);
          errors++;
        end
        if (rsp_bus.word_index != want.index) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.index,
                   rsp_bus.word_index);
          errors++;
        end
        if (rsp_bus.word_class != want.cls) begin
          $display("%0t: word_class expected %0d actual %0d", $time, want.cls,
                   rsp_bus.word_class);
          errors++;
        end
        if (rsp_bus.exact_match != want.exact) begin
          $display("%0t: exact_match expected %0d actual %0d", $time, want.exact,
                   rsp_bus.exact_match);
          errors++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    errors = 0;
    words_sent = 0;
    hold_request = 0;
    tok_len = 0;
    end_code = 5'd31;
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= 5'd0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= REQ_LOAD;
    req_bus.dict_addr <= 7'd0;
    req_bus.dict_byte <= 8'd0;
    req_bus.token_char <= 8'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_end_code(5'd31);
    test_dictionary_load();
    test_directed_lookups();
    test_back_pressure();
    test_random_traffic(5'd31, ITEMS_PER_PHASE);
    test_random_traffic(5'd0, ITEMS_PER_PHASE);
    test_random_traffic(5'($urandom_range(1, 30)), ITEMS_PER_PHASE);
    test_random_traffic(5'd5, ITEMS_PER_PHASE);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/pdpm_pkg.sv
src/pdpm_ifs.sv
src/pdpm_ram.sv
src/pdpm_ctrl.sv
src/pdpm_dp.sv
src/packed_dictionary_prefix_matcher_unit.sv
sim/packed_dictionary_prefix_matcher_unit_tb.sv
